FILE: src/nwd_pkg.sv
// ----------------------------------------------------------------------------
// nwd_pkg
// Shared types and codes for the nearest worker dispatcher.
// ----------------------------------------------------------------------------
package nwd_pkg;

	// command codes on the input channel
	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_TASK = 2'd1,
		CMD_ASK  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_ASSIGN  = 2'd1,
		KIND_BLOCKED = 2'd2,
		KIND_DROP    = 2'd3
	} kind_t;

	// worker modes held per table entry
	typedef enum logic [1:0] {
		MODE_UNLOADED = 2'd0,
		MODE_NEW      = 2'd1,
		MODE_BLOCKED  = 2'd2,
		MODE_READY    = 2'd3
	} mode_t;

	// worker state before an assignment
	typedef enum logic [1:0] {
		FROM_NEW     = 2'd0,
		FROM_BLOCKED = 2'd1,
		FROM_ASKING  = 2'd2
	} from_t;

	// one worker table word
	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] held;
		logic [7:0] target;
	} worker_t;

	// one pending task word
	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
	} task_t;

	// one result item without its last flag
	typedef struct packed {
		kind_t      kind;
		logic [2:0] worker;
		logic [7:0] x;
		logic [7:0] y;
		from_t      from;
	} result_t;

	// control of the nearest-entry search
	typedef struct packed {
		logic clr;
		logic step;
	} scan_ctrl_t;

endpackage

FILE: src/nwd_ram.sv
// ----------------------------------------------------------------------------
// nwd_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nwd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/nwd_argmin.sv
// ----------------------------------------------------------------------------
// nwd_argmin
// Running minimum of Manhattan distance over a stream of candidates.
// ----------------------------------------------------------------------------
module nwd_argmin #(
	parameter int IDX_W = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nwd_pkg::scan_ctrl_t    ctrl,
	input  logic                   cand_ok,
	input  logic [IDX_W-1:0]       cand_idx,
	input  logic [7:0]             ax,
	input  logic [7:0]             ay,
	input  logic [7:0]             bx,
	input  logic [7:0]             by,
	output logic                   found,
	output logic [IDX_W-1:0]       best_idx
);
	import nwd_pkg::*;

	logic [7:0]       dx;
	logic [7:0]       dy;
	logic [8:0]       dsum;
	logic             take;
	logic             found_q;
	logic [8:0]       bestd_q;
	logic [IDX_W-1:0] best_q;

	// distance of the candidate; strict compare keeps the earliest on ties
	always_comb begin
		dx   = (ax > bx) ? ax - bx : bx - ax;
		dy   = (ay > by) ? ay - by : by - ay;
		dsum = {1'b0, dx} + {1'b0, dy};
		take = ctrl.step && cand_ok && (!found_q || dsum < bestd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// hold best candidate
	always_ff @(posedge clk) begin
		if (take && !ctrl.clr) begin
			bestd_q <= dsum;
			best_q  <= cand_idx;
		end
	end

	assign found    = found_q;
	assign best_idx = best_q;

endmodule

FILE: src/nearest_worker_dispatcher_core.sv
// ----------------------------------------------------------------------------
// nearest_worker_dispatcher_core
// Worker table and pending task queue in RAMs; tasks go to the nearest
// eligible worker, asking workers take the nearest pending task.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   in      | input     | in_valid/in_ready  | cmd worker_index pos_x pos_y
//           |           |                    | held_count target_count
//   out     | output    | out_valid/out_ready| kind assigned_worker task_x task_y
//           |           |                    | from_state last
//
// A task walk reads the worker RAM once per worker for each assigned task,
// one read per cycle, and ends with the final result.
// An ask with tasks pending does one pending RAM read per cycle for the
// search, then one per cycle to close the gap.
// Reset clears worker modes, queue count and pointer; no clearing pass.
// A stalled output holds the block once a second result is ready.
// ----------------------------------------------------------------------------
module nearest_worker_dispatcher_core #(
	parameter int WORKERS       = 8,
	parameter int PENDING_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [2:0] worker_index,
	input  logic [7:0] pos_x,
	input  logic [7:0] pos_y,
	input  logic [7:0] held_count,
	input  logic [7:0] target_count,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [2:0] assigned_worker,
	output logic [7:0] task_x,
	output logic [7:0] task_y,
	output logic [1:0] from_state,
	output logic       last
);
	import nwd_pkg::*;

	localparam int WW  = $clog2(WORKERS);
	localparam int PW  = $clog2(PENDING_DEPTH);
	localparam int SW  = (WW > PW) ? WW : PW;
	localparam int SCW = SW + 1;
	localparam logic [PW:0]    DEPTH_C   = (PW+1)'(PENDING_DEPTH);
	localparam logic [SCW-1:0] WORKERS_C = SCW'(WORKERS);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_WSTART = 11'b00000000010,
		S_WSCAN  = 11'b00000000100,
		S_WDONE  = 11'b00000001000,
		S_AREAD  = 11'b00000010000,
		S_ACHK   = 11'b00000100000,
		S_TSCAN  = 11'b00001000000,
		S_TGET   = 11'b00010000000,
		S_TTAKE  = 11'b00100000000,
		S_SHIFT  = 11'b01000000000,
		S_FINAL  = 11'b10000000000
	} state_t;

	state_t           state_q;
	mode_t            mode_q [WORKERS];
	logic [PW:0]      cnt_q;
	logic [PW-1:0]    head_q;
	logic [SCW-1:0]   sc_q;
	logic             vld_s1;
	logic [SW-1:0]    idx_s1;
	logic [2:0]       idx_q;
	result_t          hold_q;
	logic             hold_v_q;
	result_t          out_q;
	logic             out_last_q;
	logic             out_valid_q;

	logic             in_xfer;
	logic             slot_free;
	logic             idx_ok;
	logic [WW-1:0]    in_waddr;
	logic [WW-1:0]    ask_waddr;
	logic             full;
	logic             emit;
	result_t          emit_res;
	logic             walk_adv;
	logic [WW-1:0]    best_w;

	logic             wram_we;
	logic             wram_re;
	logic [WW-1:0]    wram_raddr;
	worker_t          wram_wdata;
	worker_t          wram_rdata;
	logic             pram_we;
	logic [PW-1:0]    pram_waddr;
	task_t            pram_wdata;
	logic             pram_re;
	logic [PW-1:0]    pram_raddr;
	task_t            pram_rdata;

	scan_ctrl_t       sc_ctrl;
	logic             cand_ok;
	logic             found;
	logic [SW-1:0]    best_idx;

	// map a queue position to its RAM address
	function automatic logic [PW-1:0] phys(input logic [PW-1:0] head,
	                                       input logic [PW:0] lg);
		logic [PW:0] s;
		s = {1'b0, head} + lg;
		if (s >= DEPTH_C) begin
			s = s - DEPTH_C;
		end
		return s[PW-1:0];
	endfunction

	function automatic logic eligible(input mode_t m, input logic [7:0] h,
	                                  input logic [7:0] t);
		return (m == MODE_NEW) || ((m == MODE_BLOCKED) && (h < t));
	endfunction

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign idx_ok    = (int'(worker_index) < WORKERS);
	assign in_waddr  = WW'(worker_index);
	assign ask_waddr = WW'(idx_q);
	assign full      = (cnt_q == DEPTH_C);
	assign best_w    = best_idx[WW-1:0];
	assign walk_adv  = !hold_v_q || slot_free;

	// result emission into the output register
	always_comb begin
		emit = ((state_q == S_WDONE) && found && hold_v_q && slot_free) ||
		       ((state_q == S_FINAL) && slot_free);
		emit_res = hold_q;
		if ((state_q == S_FINAL) && !hold_v_q) begin
			emit_res = '{KIND_ACK, 3'd0, 8'd0, 8'd0, FROM_NEW};
		end
	end

	// worker RAM ports
	always_comb begin
		wram_we    = in_xfer && (cmd_t'(cmd) == CMD_LOAD) && idx_ok;
		wram_wdata = '{pos_x, pos_y, held_count, target_count};
		wram_re    = ((state_q == S_WSCAN) && (sc_q < WORKERS_C)) ||
		             (state_q == S_AREAD);
		wram_raddr = (state_q == S_AREAD) ? ask_waddr : sc_q[WW-1:0];
	end

	// pending RAM ports
	always_comb begin
		pram_we    = (in_xfer && (cmd_t'(cmd) == CMD_TASK) && !full) ||
		             ((state_q == S_SHIFT) && vld_s1);
		pram_waddr = (state_q == S_IDLE) ? phys(head_q, cnt_q) :
		             phys(head_q, (PW+1)'(idx_s1) - (PW+1)'(1));
		pram_wdata = (state_q == S_IDLE) ? task_t'({pos_x, pos_y}) : pram_rdata;
		pram_re    = (state_q == S_WSTART) || (state_q == S_TGET) ||
		             (((state_q == S_TSCAN) || (state_q == S_SHIFT)) &&
		              (sc_q < SCW'(cnt_q)));
		if (state_q == S_WSTART) begin
			pram_raddr = head_q;
		end else if (state_q == S_TGET) begin
			pram_raddr = phys(head_q, (PW+1)'(best_idx));
		end else begin
			pram_raddr = phys(head_q, (PW+1)'(sc_q));
		end
	end

	// search control
	always_comb begin
		sc_ctrl.clr  = (state_q == S_WSTART) || (state_q == S_ACHK);
		sc_ctrl.step = vld_s1 && ((state_q == S_WSCAN) || (state_q == S_TSCAN));
		cand_ok      = (state_q == S_TSCAN) ||
		               eligible(mode_q[idx_s1[WW-1:0]], wram_rdata.held,
		                        wram_rdata.target);
	end

	nwd_ram #(.WIDTH($bits(worker_t)), .DEPTH(WORKERS)) u_wram (
		.clk   (clk),
		.we    (wram_we),
		.waddr (in_waddr),
		.wdata (wram_wdata),
		.re    (wram_re),
		.raddr (wram_raddr),
		.rdata (wram_rdata)
	);

	nwd_ram #(.WIDTH($bits(task_t)), .DEPTH(PENDING_DEPTH)) u_pram (
		.clk   (clk),
		.we    (pram_we),
		.waddr (pram_waddr),
		.wdata (pram_wdata),
		.re    (pram_re),
		.raddr (pram_raddr),
		.rdata (pram_rdata)
	);

	nwd_argmin #(.IDX_W(SW)) u_argmin (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (sc_ctrl),
		.cand_ok  (cand_ok),
		.cand_idx (idx_s1),
		.ax       (wram_rdata.x),
		.ay       (wram_rdata.y),
		.bx       (pram_rdata.x),
		.by       (pram_rdata.y),
		.found    (found),
		.best_idx (best_idx)
	);

	// sequencer, modes, queue pointers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			head_q      <= '0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
			for (int i = 0; i < WORKERS; i++) begin
				mode_q[i] <= MODE_UNLOADED;
			end
		end else begin
			vld_s1 <= 1'b0;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						case (cmd_t'(cmd))
							CMD_LOAD: begin
								if (idx_ok) begin
									mode_q[in_waddr] <= MODE_NEW;
								end
								hold_v_q <= 1'b1;
								state_q  <= S_FINAL;
							end
							CMD_TASK: begin
								if (full) begin
									hold_v_q <= 1'b1;
									state_q  <= S_FINAL;
								end else begin
									cnt_q    <= cnt_q + (PW+1)'(1);
									hold_v_q <= 1'b0;
									state_q  <= S_WSTART;
								end
							end
							CMD_ASK: begin
								hold_v_q <= 1'b1;
								if (!idx_ok || mode_q[in_waddr] == MODE_UNLOADED) begin
									state_q <= S_FINAL;
								end else if (cnt_q == '0) begin
									mode_q[in_waddr] <= MODE_BLOCKED;
									state_q          <= S_FINAL;
								end else begin
									state_q <= S_AREAD;
								end
							end
							default: begin
								hold_v_q <= 1'b1;
								state_q  <= S_FINAL;
							end
						endcase
					end
				end
				S_WSTART: begin
					state_q <= S_WSCAN;
				end
				S_WSCAN: begin
					if (sc_q < WORKERS_C) begin
						vld_s1 <= 1'b1;
					end else begin
						state_q <= S_WDONE;
					end
				end
				S_WDONE: begin
					if (!found) begin
						state_q <= S_FINAL;
					end else if (walk_adv) begin
						mode_q[best_w] <= MODE_READY;
						hold_v_q       <= 1'b1;
						cnt_q          <= cnt_q - (PW+1)'(1);
						head_q         <= phys(head_q, (PW+1)'(1));
						state_q        <= (cnt_q == (PW+1)'(1)) ? S_FINAL : S_WSTART;
					end
				end
				S_AREAD: begin
					state_q <= S_ACHK;
				end
				S_ACHK: begin
					if (wram_rdata.held >= wram_rdata.target) begin
						state_q <= S_FINAL;
					end else begin
						state_q <= S_TSCAN;
					end
				end
				S_TSCAN: begin
					if (sc_q < SCW'(cnt_q)) begin
						vld_s1 <= 1'b1;
					end else begin
						state_q <= S_TGET;
					end
				end
				S_TGET: begin
					state_q <= S_TTAKE;
				end
				S_TTAKE: begin
					mode_q[ask_waddr] <= MODE_READY;
					state_q           <= S_SHIFT;
				end
				S_SHIFT: begin
					if (sc_q < SCW'(cnt_q)) begin
						vld_s1 <= 1'b1;
					end else begin
						cnt_q   <= cnt_q - (PW+1)'(1);
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					if (slot_free) begin
						hold_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: scan counter, captured index, held result, output register
	always_ff @(posedge clk) begin
		idx_s1 <= sc_q[SW-1:0];
		case (state_q)
			S_IDLE: begin
				idx_q <= worker_index;
				case (cmd_t'(cmd))
					CMD_LOAD: hold_q <= '{KIND_ACK, worker_index, 8'd0, 8'd0, FROM_NEW};
					CMD_TASK: hold_q <= '{KIND_DROP, 3'd0, pos_x, pos_y, FROM_NEW};
					CMD_ASK: begin
						if (idx_ok && mode_q[in_waddr] != MODE_UNLOADED && cnt_q == '0) begin
							hold_q <= '{KIND_BLOCKED, worker_index, 8'd0, 8'd0,
							            FROM_ASKING};
						end else begin
							hold_q <= '{KIND_ACK, worker_index, 8'd0, 8'd0, FROM_NEW};
						end
					end
					default: hold_q <= '{KIND_ACK, 3'd0, 8'd0, 8'd0, FROM_NEW};
				endcase
			end
			S_WSTART, S_ACHK: begin
				sc_q <= '0;
			end
			S_WSCAN: begin
				if (sc_q < WORKERS_C) begin
					sc_q <= sc_q + SCW'(1);
				end
			end
			S_TSCAN, S_SHIFT: begin
				if (sc_q < SCW'(cnt_q)) begin
					sc_q <= sc_q + SCW'(1);
				end
			end
			S_WDONE: begin
				if (found && walk_adv) begin
					hold_q <= '{KIND_ASSIGN, 3'(best_idx), pram_rdata.x, pram_rdata.y,
					            (mode_q[best_w] == MODE_NEW) ? FROM_NEW : FROM_BLOCKED};
				end
			end
			S_TTAKE: begin
				hold_q <= '{KIND_ASSIGN, idx_q, pram_rdata.x, pram_rdata.y, FROM_ASKING};
				sc_q   <= SCW'(best_idx) + SCW'(1);
			end
			default: begin
				sc_q <= sc_q;
			end
		endcase
		if (emit) begin
			out_q      <= emit_res;
			out_last_q <= (state_q == S_FINAL);
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = out_q.kind;
	assign assigned_worker = out_q.worker;
	assign task_x          = out_q.x;
	assign task_y          = out_q.y;
	assign from_state      = out_q.from;
	assign last            = out_last_q;

	// queue never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("pending count above depth");

	// block is busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("ready right after accept");

	// each walk assignment pops one task off the queue
	a_walk_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WDONE && found && walk_adv) |=>
		(cnt_q == $past(cnt_q) - (PW+1)'(1)))
		else $error("walk assignment did not pop");

	// drop results always close their item
	a_drop_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind == KIND_DROP) |-> out_last_q)
		else $error("drop result without last");

endmodule
